/* design/jtag_bitbang_shifter_defines.svh */
// ----------------------------------------------------------------------------
// JTAG bit-bang shifter assertion macros
// Shared property wrappers for the shifter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef JTAG_BITBANG_SHIFTER_DEFINES_SVH
`define JTAG_BITBANG_SHIFTER_DEFINES_SVH

// Check a same-cycle implication, skipped while reset is held
`define JBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, skipped while reset is held
`define JBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/jbs_pkg.sv */
// ----------------------------------------------------------------------------
// JTAG bit-bang shifter package
// Item, configuration and result types plus fixed codes and constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jbs_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 6;
    localparam int HALF_W  = 16;
    localparam int IDX_W   = 2;
    localparam int PORT_W  = 2;

    // Longest transfer; larger bit counts saturate to it
    localparam int MAX_BITS = 32;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DUAL_PASS   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_PORT_INDEX  = 2'd2;

    localparam logic [HALF_W-1:0] RESET_HALF_PERIOD = 16'd50;

    // Item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic [HALF_W-1:0] half_period;
        logic              dual_pass;
        logic [PORT_W-1:0] port_index;
    } t_cfg;

    typedef struct packed {
        logic               opcode;
        logic [COUNT_W-1:0] bit_count;
        logic [WORD_W-1:0]  tms_bits;
        logic [WORD_W-1:0]  tdi_bits;
        logic               tdo_pin;
    } t_item;

    typedef struct packed {
        logic tck;
        logic tms;
        logic tdi;
        logic side;
    } t_pins;

    localparam t_pins PINS_RESET = '{tck: 1'b0, tms: 1'b1, tdi: 1'b0, side: 1'b1};

    typedef struct packed {
        t_pins             pins;
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] word;
    } t_result;

endpackage

/* design/jbs_engine.sv */
// ----------------------------------------------------------------------------
// JTAG bit-bang shifter engine
// Holds the shift state and advances it by one item per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jbs_engine
    import jbs_pkg::*;
#(
    parameter int DELAY_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int            CW  = $clog2(MAX_BITS + 1);
    localparam logic [COUNT_W:0] SAT = (COUNT_W + 1)'(MAX_BITS);

    logic [DELAY_WIDTH-1:0] r_tick, n_tick;
    logic [CW-1:0]          r_bit_idx, n_bit_idx;
    logic [CW-1:0]          r_bit_total, n_bit_total;
    logic [WORD_W-1:0]      r_tms_shift, n_tms_shift;
    logic [WORD_W-1:0]      r_tdi_shift, n_tdi_shift;
    logic [WORD_W-1:0]      r_tms_saved, n_tms_saved;
    logic [WORD_W-1:0]      r_tdi_saved, n_tdi_saved;
    logic [WORD_W-1:0]      r_tdo_accum, n_tdo_accum;
    logic [WORD_W-1:0]      r_first_word, n_first_word;
    logic                   r_pass_second, n_pass_second;
    logic                   r_high, n_high;
    logic                   r_running, n_running;
    t_pins                  r_pins, n_pins;

    logic [DELAY_WIDTH-1:0] half_raw;
    logic [DELAY_WIDTH-1:0] half_limit;
    logic [DELAY_WIDTH-1:0] tick_inc;
    logic [CW-1:0]          bit_next;
    logic [COUNT_W:0]       count_ext;
    logic [CW-1:0]          count_sat;
    logic [WORD_W-1:0]      tms_next_shift;
    logic [WORD_W-1:0]      tdi_next_shift;
    logic                   start;
    logic                   done;
    logic [WORD_W-1:0]      word;

    // Derive the half-period length, the saturated count and the shifted bits
    always_comb begin
        half_raw       = DELAY_WIDTH'(i_cfg.half_period);
        half_limit     = (half_raw == '0) ? DELAY_WIDTH'(1) : half_raw;
        tick_inc       = r_tick + 1'b1;
        bit_next       = r_bit_idx + 1'b1;
        count_ext      = {1'b0, i_item.bit_count};
        count_sat      = (count_ext > SAT) ? CW'(SAT) : CW'(count_ext);
        tms_next_shift = r_tms_shift >> 1;
        tdi_next_shift = r_tdi_shift >> 1;
        start          = (i_item.opcode == OP_START) && !r_running;
    end

    // Advance the sequencer by one item
    always_comb begin
        n_tick        = r_tick;
        n_bit_idx     = r_bit_idx;
        n_bit_total   = r_bit_total;
        n_tms_shift   = r_tms_shift;
        n_tdi_shift   = r_tdi_shift;
        n_tms_saved   = r_tms_saved;
        n_tdi_saved   = r_tdi_saved;
        n_tdo_accum   = r_tdo_accum;
        n_first_word  = r_first_word;
        n_pass_second = r_pass_second;
        n_high        = r_high;
        n_running     = r_running;
        n_pins        = r_pins;
        done          = 1'b0;
        word          = '0;

        if (i_step) begin
            if (start) begin
                // Load a new transfer and open the first low half, or finish at once on a zero count
                n_tms_saved   = i_item.tms_bits;
                n_tdi_saved   = i_item.tdi_bits;
                n_first_word  = '0;
                n_pass_second = 1'b0;
                n_bit_total   = count_sat;
                n_tdo_accum   = '0;
                if (count_sat == '0) begin
                    if (i_cfg.dual_pass) begin
                        n_pins.side = 1'b1;
                    end
                    done = 1'b1;
                end else begin
                    if (i_cfg.dual_pass) begin
                        n_pins.side = 1'b0;
                    end
                    n_running   = 1'b1;
                    n_tms_shift = i_item.tms_bits;
                    n_tdi_shift = i_item.tdi_bits;
                    n_bit_idx   = '0;
                    n_pins.tck  = 1'b0;
                    n_pins.tms  = i_item.tms_bits[0];
                    n_pins.tdi  = i_item.tdi_bits[0];
                    n_high      = 1'b0;
                    n_tick      = '0;
                end
            end else if (r_running) begin
                if (tick_inc < half_limit) begin
                    n_tick = tick_inc;
                end else begin
                    n_tick = '0;
                    if (!r_high) begin
                        // End of low half: sample TDO, raise TCK
                        if (i_item.tdo_pin) begin
                            n_tdo_accum = r_tdo_accum | (WORD_W'(1) << r_bit_idx);
                        end
                        n_pins.tck = 1'b1;
                        n_high     = 1'b1;
                    end else begin
                        // End of high half: move to the next bit
                        n_tms_shift = tms_next_shift;
                        n_tdi_shift = tdi_next_shift;
                        n_bit_idx   = bit_next;
                        if (bit_next < r_bit_total) begin
                            n_pins.tck = 1'b0;
                            n_pins.tms = tms_next_shift[0];
                            n_pins.tdi = tdi_next_shift[0];
                            n_high     = 1'b0;
                        end else if (!r_pass_second && i_cfg.dual_pass) begin
                            // Rerun the sequence on the other side
                            n_first_word  = r_tdo_accum;
                            n_pass_second = 1'b1;
                            n_pins.side   = 1'b1;
                            n_tms_shift   = r_tms_saved;
                            n_tdi_shift   = r_tdi_saved;
                            n_tdo_accum   = '0;
                            n_bit_idx     = '0;
                            n_pins.tck    = 1'b0;
                            n_pins.tms    = r_tms_saved[0];
                            n_pins.tdi    = r_tdi_saved[0];
                            n_high        = 1'b0;
                        end else begin
                            n_running = 1'b0;
                            done      = 1'b1;
                            word      = r_pass_second ? r_first_word : r_tdo_accum;
                        end
                    end
                end
            end
        end
    end

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_bit_idx     <= '0;
            r_bit_total   <= '0;
            r_tms_shift   <= '0;
            r_tdi_shift   <= '0;
            r_tms_saved   <= '0;
            r_tdi_saved   <= '0;
            r_tdo_accum   <= '0;
            r_first_word  <= '0;
            r_pass_second <= 1'b0;
            r_high        <= 1'b0;
            r_running     <= 1'b0;
            r_pins        <= PINS_RESET;
        end else begin
            r_tick        <= n_tick;
            r_bit_idx     <= n_bit_idx;
            r_bit_total   <= n_bit_total;
            r_tms_shift   <= n_tms_shift;
            r_tdi_shift   <= n_tdi_shift;
            r_tms_saved   <= n_tms_saved;
            r_tdi_saved   <= n_tdi_saved;
            r_tdo_accum   <= n_tdo_accum;
            r_first_word  <= n_first_word;
            r_pass_second <= n_pass_second;
            r_high        <= n_high;
            r_running     <= n_running;
            r_pins        <= n_pins;
        end
    end

    assign o_result = '{pins: n_pins, busy: n_running, done: done, word: word};

endmodule

/* design/jtag_bitbang_shifter.sv */
// ----------------------------------------------------------------------------
// JTAG bit-bang shifter
// Sequences TCK/TMS/TDI and captures TDO, one result per tick or start item.
// ----------------------------------------------------------------------------
// Every input transfer is one time tick or one start request and gives exactly
// one result transfer with the pin levels after it. The block takes one item
// per clock cycle when the result side keeps up; each item waits in the input
// register until the engine steps it, and its result is then registered in the
// output register, which offers it until the result transfer completes.
// The rate is set by the sequencer state update in the engine, which handles
// one item per cycle while the result side keeps up. A transfer of N bits needs
// 2 * N * max(half_period_ticks, 1) tick items, twice that in dual-pass mode.
// Configuration writes take effect on the next clock edge.
`timescale 1ns / 1ps

`include "jtag_bitbang_shifter_defines.svh"

module jtag_bitbang_shifter
    import jbs_pkg::*;
#(
    parameter int DELAY_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [HALF_W-1:0] i_cfg_data,
    // input item channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_opcode,
    input  logic [COUNT_W-1:0] i_bit_count,
    input  logic [WORD_W-1:0] i_tms_bits,
    input  logic [WORD_W-1:0] i_tdi_bits,
    input  logic              i_tdo_pin,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_tck_level,
    output logic              o_tms_level,
    output logic              o_tdi_level,
    output logic              o_side_level,
    output logic [PORT_W-1:0] o_port_out,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [WORD_W-1:0] o_tdo_word
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    t_item             r_item;
    logic              r_out_valid;
    t_result           r_out_res;
    logic [PORT_W-1:0] r_out_port;

    t_result           step_res;
    logic              step;
    logic              in_xfer;
    logic              out_xfer;

    // Process the held item when the result register is free or draining
    assign step     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || step;
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = r_out_valid && i_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{half_period: RESET_HALF_PERIOD, dual_pass: 1'b0, port_index: '0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HALF_PERIOD: r_cfg.half_period <= i_cfg_data;
                CFG_DUAL_PASS:   r_cfg.dual_pass   <= i_cfg_data[0];
                CFG_PORT_INDEX:  r_cfg.port_index  <= i_cfg_data[PORT_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // Capture an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= '{opcode: i_opcode, bit_count: i_bit_count, tms_bits: i_tms_bits,
                        tdi_bits: i_tdi_bits, tdo_pin: i_tdo_pin};
        end
    end

    jbs_engine #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (step_res)
    );

    // Hold the result until its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_res  <= step_res;
            r_out_port <= r_cfg.port_index;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tck_level  = r_out_res.pins.tck;
    assign o_tms_level  = r_out_res.pins.tms;
    assign o_tdi_level  = r_out_res.pins.tdi;
    assign o_side_level = r_out_res.pins.side;
    assign o_port_out   = r_out_port;
    assign o_busy_res   = r_out_res.busy;
    assign o_done_res   = r_out_res.done;
    assign o_tdo_word   = r_out_res.word;

    // Checks
    `JBS_ASSERT_IMP(a_done_not_busy, o_valid && o_done_res, !o_busy_res, "done with busy set")
    `JBS_ASSERT_IMP(a_word_only_done, o_valid && !o_done_res, o_tdo_word == '0, "word without done")
    `JBS_ASSERT_IMP(a_stall_only_full, !o_ready, r_in_valid && r_out_valid && !i_ready, "bad stall")
    `JBS_ASSERT_NEXT(a_step_fills_out, step, r_out_valid, "result lost")

endmodule

/* tb/sv/tb_jtag_bitbang_shifter.sv */
// ----------------------------------------------------------------------------
// JTAG bit-bang shifter testbench
// Drives tick and start items and checks every pin snapshot against a
// cycle-free model of the TCK/TMS/TDI sequencer and TDO capture, with random
// stalls on both channels and register changes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_jtag_bitbang_shifter;
    import jbs_pkg::*;

    localparam int LEN_MAX     = 32;
    localparam int SEG_ITEMS   = 240;
    localparam int SEGMENTS    = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        t_pins             pins;
        logic [PORT_W-1:0] port;
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] word;
    } t_pin_snapshot;

    // Tracks the sequencer and holds the snapshots still owed by the block
    class t_jtag_pin_tracker;
        logic [HALF_W-1:0] half_period;
        logic              dual_pass;
        logic [PORT_W-1:0] port_index;

        int unsigned        tick_cnt;
        logic [COUNT_W-1:0] bit_idx;
        logic [COUNT_W-1:0] bit_total;
        logic [WORD_W-1:0]  tms_sh, tdi_sh, tms_load, tdi_load;
        logic [WORD_W-1:0]  tdo_acc, first_word;
        logic               second_pass, high_phase, running;
        t_pins              pins;

        t_pin_snapshot pins_due[$];
        int accepted, checked, transfers, mismatches;

        function new();
            half_period = RESET_HALF_PERIOD;
            dual_pass   = 1'b0;
            port_index  = '0;
            tick_cnt    = 0;
            bit_idx     = '0;
            bit_total   = '0;
            tms_sh      = '0;
            tdi_sh      = '0;
            tms_load    = '0;
            tdi_load    = '0;
            tdo_acc     = '0;
            first_word  = '0;
            second_pass = 1'b0;
            high_phase  = 1'b0;
            running     = 1'b0;
            pins        = PINS_RESET;
            accepted    = 0;
            checked     = 0;
            transfers   = 0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [HALF_W-1:0] val);
            case (idx)
                CFG_HALF_PERIOD: half_period = val;
                CFG_DUAL_PASS:   dual_pass = val[0];
                CFG_PORT_INDEX:  port_index = val[PORT_W-1:0];
                default: ;
            endcase
        endfunction

        // Enter the low TCK half with the current shift bits on the pins
        function void low_half();
            pins.tck   = 1'b0;
            pins.tms   = tms_sh[0];
            pins.tdi   = tdi_sh[0];
            high_phase = 1'b0;
            tick_cnt   = 0;
        endfunction

        function void restart_pass();
            tms_sh  = tms_load;
            tdi_sh  = tdi_load;
            tdo_acc = '0;
            bit_idx = '0;
            low_half();
        endfunction

        // Advance one tick; flag the end of a transfer with its word
        function void advance(logic tdo, output logic fin, output logic [WORD_W-1:0] w);
            int unsigned limit;
            fin   = 1'b0;
            w     = '0;
            limit = (half_period == '0) ? 1 : int'(half_period);
            if (!running) return;
            tick_cnt++;
            if (tick_cnt < limit) return;
            tick_cnt = 0;
            if (!high_phase) begin
                if (tdo) tdo_acc[bit_idx[4:0]] = 1'b1;
                pins.tck   = 1'b1;
                high_phase = 1'b1;
                return;
            end
            tms_sh  = tms_sh >> 1;
            tdi_sh  = tdi_sh >> 1;
            bit_idx = bit_idx + 1'b1;
            if (bit_idx < bit_total) begin
                low_half();
                return;
            end
            if (!second_pass && dual_pass) begin
                first_word  = tdo_acc;
                second_pass = 1'b1;
                pins.side   = 1'b1;
                restart_pass();
                return;
            end
            running = 1'b0;
            fin     = 1'b1;
            w       = second_pass ? first_word : tdo_acc;
        endfunction

        // Note an accepted item and queue the snapshot it must produce
        function void note_item(t_item it);
            t_pin_snapshot      snap;
            logic               fin;
            logic [WORD_W-1:0]  w;
            logic [COUNT_W-1:0] n;
            fin = 1'b0;
            w   = '0;
            accepted++;
            if (it.opcode == OP_START && !running) begin
                n           = (it.bit_count > LEN_MAX) ? COUNT_W'(LEN_MAX) : it.bit_count;
                tms_load    = it.tms_bits;
                tdi_load    = it.tdi_bits;
                first_word  = '0;
                second_pass = 1'b0;
                bit_total   = n;
                if (n == '0) begin
                    if (dual_pass) pins.side = 1'b1;
                    tdo_acc = '0;
                    fin     = 1'b1;
                end else begin
                    if (dual_pass) pins.side = 1'b0;
                    running = 1'b1;
                    restart_pass();
                end
            end else begin
                advance(it.tdo_pin, fin, w);
            end
            if (fin) transfers++;
            snap.pins = pins;
            snap.port = port_index;
            snap.busy = running;
            snap.done = fin;
            snap.word = fin ? w : '0;
            pins_due.push_back(snap);
        endfunction

        // Compare one result transfer with the oldest snapshot owed
        function void check_result(t_pin_snapshot got);
            t_pin_snapshot exp;
            string         bad;
            checked++;
            if (pins_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: result with nothing outstanding: %p", got);
                return;
            end
            exp = pins_due.pop_front();
            bad = "";
            if (got.pins.tck !== exp.pins.tck)   bad = {bad, " tck"};
            if (got.pins.tms !== exp.pins.tms)   bad = {bad, " tms"};
            if (got.pins.tdi !== exp.pins.tdi)   bad = {bad, " tdi"};
            if (got.pins.side !== exp.pins.side) bad = {bad, " side"};
            if (got.port !== exp.port)           bad = {bad, " port"};
            if (got.busy !== exp.busy)           bad = {bad, " busy"};
            if (got.done !== exp.done)           bad = {bad, " done"};
            if (got.word !== exp.word)           bad = {bad, " word"};
            if (bad == "") return;
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("ERROR: result %0d differs in%s", checked, bad);
                $display("  expected tck=%b tms=%b tdi=%b side=%b port=%0d busy=%b done=%b word=%h",
                         exp.pins.tck, exp.pins.tms, exp.pins.tdi, exp.pins.side,
                         exp.port, exp.busy, exp.done, exp.word);
                $display("  actual   tck=%b tms=%b tdi=%b side=%b port=%0d busy=%b done=%b word=%h",
                         got.pins.tck, got.pins.tms, got.pins.tdi, got.pins.side,
                         got.port, got.busy, got.done, got.word);
            end
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx   = '0;
    logic [HALF_W-1:0]  i_cfg_data  = '0;
    logic               i_valid     = 1'b0;
    logic               i_opcode    = 1'b0;
    logic [COUNT_W-1:0] i_bit_count = '0;
    logic [WORD_W-1:0]  i_tms_bits  = '0;
    logic [WORD_W-1:0]  i_tdi_bits  = '0;
    logic               i_tdo_pin   = 1'b0;
    logic               i_ready     = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic               o_tck_level, o_tms_level, o_tdi_level, o_side_level;
    logic [PORT_W-1:0]  o_port_out;
    logic               o_busy_res, o_done_res;
    logic [WORD_W-1:0]  o_tdo_word;

    int send_idle_pct = 33;
    int recv_idle_pct = 88;
    int stall_cycles  = 0;

    t_jtag_pin_tracker tracker = new();

    jtag_bitbang_shifter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_bit_count  (i_bit_count),
        .i_tms_bits   (i_tms_bits),
        .i_tdi_bits   (i_tdi_bits),
        .i_tdo_pin    (i_tdo_pin),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tck_level  (o_tck_level),
        .o_tms_level  (o_tms_level),
        .o_tdi_level  (o_tdi_level),
        .o_side_level (o_side_level),
        .o_port_out   (o_port_out),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_tdo_word   (o_tdo_word)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side at random and check every result transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                tracker.check_result('{pins: '{tck: o_tck_level, tms: o_tms_level,
                                               tdi: o_tdi_level, side: o_side_level},
                                       port: o_port_out, busy: o_busy_res,
                                       done: o_done_res, word: o_tdo_word});
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                     stall_cycles, tracker.pins_due.size());
            $display("jtag_bitbang_shifter: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_item make_item(logic op, logic [COUNT_W-1:0] n,
                                        logic [WORD_W-1:0] tms, logic [WORD_W-1:0] tdi,
                                        logic tdo);
        t_item it;
        it.opcode    = op;
        it.bit_count = n;
        it.tms_bits  = tms;
        it.tdi_bits  = tdi;
        it.tdo_pin   = tdo;
        return it;
    endfunction

    // Mostly starts when idle and ticks when busy, with some noise either way
    function automatic t_item rand_item(logic busy);
        t_item it;
        int    pick;
        it.tms_bits  = $urandom;
        it.tdi_bits  = $urandom;
        it.tdo_pin   = 1'($urandom_range(0, 1));
        it.bit_count = COUNT_W'($urandom_range(0, 63));
        if (busy) begin
            it.opcode = ($urandom_range(0, 19) == 0) ? OP_START : OP_TICK;
        end else begin
            it.opcode = ($urandom_range(0, 9) < 7) ? OP_START : OP_TICK;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                it.bit_count = COUNT_W'($urandom_range(1, 4));
            else if (pick < 8)
                it.bit_count = COUNT_W'($urandom_range(5, 32));
            else if (pick == 8)
                it.bit_count = COUNT_W'($urandom_range(33, 63));
            else
                it.bit_count = '0;
        end
        return it;
    endfunction

    // Present one item, idling first at random, and hold it until taken
    task automatic send_item(input t_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= it.opcode;
        i_bit_count <= it.bit_count;
        i_tms_bits  <= it.tms_bits;
        i_tdi_bits  <= it.tdi_bits;
        i_tdo_pin   <= it.tdo_pin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.note_item(it);
    endtask

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [HALF_W-1:0] val);
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        tracker.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Drain all results, then rewrite the three registers
    task automatic load_cfg(input logic [HALF_W-1:0] half, input logic dual,
                            input logic [PORT_W-1:0] port);
        i_valid <= 1'b0;
        while (tracker.pins_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        put_reg(CFG_HALF_PERIOD, half);
        put_reg(CFG_DUAL_PASS, HALF_W'(dual));
        put_reg(CFG_PORT_INDEX, HALF_W'(port));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_item it;
        logic  busy;
        int    counted;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: idle tick, then a one-bit transfer at the reset period
        send_item(make_item(OP_TICK, '0, '0, '0, 1'b1));
        send_item(make_item(OP_START, 6'd1, '1, '0, 1'b0));
        repeat (3) send_item(make_item(OP_TICK, '0, '0, '0, 1'b1));

        // Longest half period while that transfer runs
        load_cfg('1, 1'b0, 2'd3);
        repeat (2) send_item(make_item(OP_TICK, '0, '0, '0, 1'b1));

        // Shortest period and dual pass switched on mid-transfer
        load_cfg('0, 1'b1, 2'd1);
        send_item(make_item(OP_TICK, '0, '0, '0, 1'b1));
        send_item(make_item(OP_START, 6'd5, '1, '1, 1'b0));
        repeat (2) send_item(make_item(OP_TICK, '0, '0, '0, 1'b0));

        // Empty transfer, then a two-bit dual-pass transfer
        send_item(make_item(OP_START, '0, '1, '1, 1'b1));
        send_item(make_item(OP_START, 6'd2, 32'h0000_0002, 32'h8000_0001, 1'b0));
        for (int k = 0; k < 8; k++)
            send_item(make_item(OP_TICK, '1, '1, '1, 1'(k < 4)));

        // Oversized count; this transfer runs on into the random part
        send_item(make_item(OP_START, 6'd63, $urandom, $urandom, 1'b1));

        // Random phases, two per idling pattern
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 2) begin
                send_idle_pct = 88;
                recv_idle_pct = 33;
            end else if (seg == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_cfg(HALF_W'($urandom_range(0, 4)), 1'($urandom_range(0, 1)),
                     PORT_W'($urandom_range(0, 3)));
            counted = 0;
            while (counted < SEG_ITEMS) begin
                busy = tracker.running;
                it   = rand_item(busy);
                if (busy ? (it.opcode == OP_TICK) : (it.opcode == OP_START))
                    counted++;
                send_item(it);
            end
        end

        // Wait out the remaining results and any stray extras
        i_valid <= 1'b0;
        while (tracker.pins_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Shifted %0d items through %0d completed transfers, %0d results compared,",
                 tracker.accepted, tracker.transfers, tracker.checked);
        $display("across %0d register settings and three stall patterns; %0d mismatches.",
                 SEGMENTS + 3, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("jtag_bitbang_shifter: match");
        else
            $display("jtag_bitbang_shifter: mismatch");
        $finish;
    end

endmodule

/* jtag_bitbang_shifter.f */
+incdir+design
design/jbs_pkg.sv
design/jbs_engine.sv
design/jtag_bitbang_shifter.sv
tb/sv/tb_jtag_bitbang_shifter.sv
